FILE: rtl/cht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_pkg
// types, constants and codes shared by the counting hash table
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int BUCKETS    = 64;
  localparam int WAYS       = 4;
  localparam int COUNT_BITS = 16;

  localparam int BUCKET_BITS = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KEY_BITS    = 32;
  localparam int PROD_BITS   = 48;
  localparam int BCNT_BITS   = 7;
  localparam int CFG_BITS    = 16;
  localparam int IDX_BITS    = 2;
  localparam int QDEPTH      = 2;
  localparam int MOD_BITS    = (BCNT_BITS > BUCKET_BITS + 1) ? BCNT_BITS : BUCKET_BITS + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [IDX_BITS-1:0] REG_MULT   = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_OFFSET = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_BCOUNT = 2'd2;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]          command;
    logic [KEY_BITS-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [15:0] occurrences;
    logic        status;
  } out_word_t;

  typedef struct packed {
    logic [1:0]             command;
    logic [KEY_BITS-1:0]    key;
    logic [BUCKET_BITS-1:0] bucket;
  } job_t;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_MOD, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_READ, B_SCAN, B_WRITE} back_state_t;

  function automatic logic [15:0] report(input logic [COUNT_BITS-1:0] c);
    logic [15:0] r;
    if (COUNT_BITS > 16 && (c >> 16) != '0) r = 16'hffff;
    else r = 16'(c);
    return r;
  endfunction

endpackage

FILE: rtl/cht_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_front
// accepts words, forms the hash product and reduces it to a bucket serially
// ----------------------------------------------------------------------------
module cht_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  cht_pkg::in_word_t             in_word,
  input  logic [cht_pkg::CFG_BITS-1:0]  hash_multiplier,
  input  logic [cht_pkg::CFG_BITS-1:0]  hash_offset,
  input  logic [cht_pkg::BCNT_BITS-1:0] bucket_count,
  input  logic                          q_full,
  output logic                          q_push,
  output cht_pkg::job_t                 q_job
);

  cht_pkg::front_state_t state, state_next;
  cht_pkg::in_word_t     item;
  logic [cht_pkg::PROD_BITS-1:0] prod;
  logic [cht_pkg::MOD_BITS-1:0]  rem, modn, rem_sh;
  logic [5:0]                    bitn;
  logic [cht_pkg::BCNT_BITS-1:0] n_c;

  always_comb begin
    if (bucket_count == '0) n_c = cht_pkg::BCNT_BITS'(1);
    else if (32'(bucket_count) > cht_pkg::BUCKETS) n_c = cht_pkg::BCNT_BITS'(cht_pkg::BUCKETS);
    else n_c = bucket_count;
  end

  // restoring remainder step, one product bit per cycle
  always_comb begin
    rem_sh = {rem[cht_pkg::MOD_BITS-2:0], prod[bitn]};
    if (rem_sh >= modn) rem_sh = rem_sh - modn;
  end

  always_comb begin
    state_next = state;
    case (state)
      cht_pkg::F_IDLE: if (start) state_next = cht_pkg::F_MUL;
      cht_pkg::F_MUL:  state_next = cht_pkg::F_MOD;
      cht_pkg::F_MOD:  if (bitn == 6'd0) state_next = cht_pkg::F_PUSH;
      cht_pkg::F_PUSH: if (!q_full) state_next = cht_pkg::F_IDLE;
      default:         state_next = cht_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != cht_pkg::F_IDLE);
    q_push = (state == cht_pkg::F_PUSH) && !q_full;
    q_job.command = item.command;
    q_job.key     = item.key;
    q_job.bucket  = cht_pkg::BUCKET_BITS'(rem);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cht_pkg::F_IDLE;
    else state <= state_next;
    case (state)
      cht_pkg::F_IDLE: if (start) begin
        item <= in_word;
        modn <= cht_pkg::MOD_BITS'(n_c);
      end
      cht_pkg::F_MUL: begin
        prod <= cht_pkg::PROD_BITS'(hash_multiplier) * cht_pkg::PROD_BITS'(item.key)
              + cht_pkg::PROD_BITS'(hash_offset);
        bitn <= 6'(cht_pkg::PROD_BITS - 1);
        rem  <= '0;
      end
      cht_pkg::F_MOD: begin
        rem  <= rem_sh;
        bitn <= bitn - 6'd1;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/cht_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_queue
// short fifo between hashing front and table back
// ----------------------------------------------------------------------------
module cht_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cht_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output cht_pkg::job_t head
);

  cht_pkg::job_t entry [cht_pkg::QDEPTH];
  logic wp, rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'(cht_pkg::QDEPTH));
  assign empty = (cnt == 2'd0);
  assign head  = entry[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) entry[wp] <= push_job;
  end

endmodule

FILE: rtl/cht_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_back
// bucket read, way scan and write back into the slot memory
// ----------------------------------------------------------------------------
module cht_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  cht_pkg::job_t      head,
  output logic               pop,
  output logic               done,
  output cht_pkg::out_word_t result
);

  localparam int SLOTS = cht_pkg::BUCKETS * cht_pkg::WAYS;
  localparam int SB = cht_pkg::BUCKET_BITS + cht_pkg::WAY_BITS;

  cht_pkg::back_state_t state, state_next;
  cht_pkg::job_t job;
  logic [cht_pkg::KEY_BITS-1:0]   mkey [SLOTS];
  logic [cht_pkg::COUNT_BITS-1:0] mcnt [SLOTS];
  logic [cht_pkg::WAYS-1:0]       vbits [cht_pkg::BUCKETS];
  logic [cht_pkg::KEY_BITS-1:0]   rkey;
  logic [cht_pkg::COUNT_BITS-1:0] rcnt;
  logic [cht_pkg::WAY_BITS-1:0]   way, hit_w, free_w;
  logic hit, freef;
  logic [cht_pkg::WAYS-1:0] vb;
  logic [SB-1:0] addr;
  logic                           we, wv;
  logic [cht_pkg::COUNT_BITS-1:0] wcnt;

  assign vb   = vbits[job.bucket];
  assign addr = (cht_pkg::WAYS > 1) ? SB'({job.bucket, hit_w}) : SB'(job.bucket);

  always_comb begin
    state_next = state;
    case (state)
      cht_pkg::B_IDLE:  if (!empty) state_next = cht_pkg::B_READ;
      cht_pkg::B_READ:  state_next = cht_pkg::B_SCAN;
      cht_pkg::B_SCAN:  if ((vb[hit_w] && rkey == job.key) || 32'(way) == cht_pkg::WAYS - 1)
                          state_next = cht_pkg::B_WRITE;
                        else state_next = cht_pkg::B_READ;
      cht_pkg::B_WRITE: state_next = cht_pkg::B_IDLE;
      default:          state_next = cht_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == cht_pkg::B_IDLE) && !empty;
    done = (state == cht_pkg::B_WRITE);
    we = 1'b0; wv = 1'b0; wcnt = rcnt;
    result = '0;
    if (job.command == cht_pkg::CMD_INSERT) begin
      if (hit) begin
        we = 1'b1; wv = 1'b1;
        if (rcnt != cht_pkg::COUNT_MAX) wcnt = rcnt + 1'b1;
        result.found = 1'b1; result.occurrences = cht_pkg::report(wcnt);
      end else if (freef) begin
        we = 1'b1; wv = 1'b1; wcnt = cht_pkg::COUNT_BITS'(1);
        result.occurrences = 16'd1;
      end else result.status = 1'b1;
    end else if (job.command == cht_pkg::CMD_DELETE) begin
      if (hit) begin
        we = 1'b1; result.found = 1'b1;
        if (rcnt > cht_pkg::COUNT_BITS'(1)) begin
          wv = 1'b1; wcnt = rcnt - 1'b1; result.occurrences = cht_pkg::report(wcnt);
        end
      end
    end else if (hit) begin
      result.found = 1'b1; result.occurrences = cht_pkg::report(rcnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cht_pkg::B_IDLE;
    else state <= state_next;
    if (rst) begin
      for (int b = 0; b < cht_pkg::BUCKETS; b++) vbits[b] <= '0;
    end else if (state == cht_pkg::B_WRITE && we) begin
      vbits[job.bucket][hit ? hit_w : free_w] <= wv;
    end
    case (state)
      cht_pkg::B_IDLE: if (!empty) begin
        job <= head; way <= '0; hit <= 1'b0; freef <= 1'b0;
        hit_w <= '0; free_w <= '0;
      end
      cht_pkg::B_READ: begin
        rkey <= mkey[addr]; rcnt <= mcnt[addr];
      end
      cht_pkg::B_SCAN: begin
        // hit_w tracks the way just read
        if (vb[hit_w] && rkey == job.key) hit <= 1'b1;
        else begin
          if (!vb[hit_w] && !freef) begin
            freef <= 1'b1; free_w <= hit_w;
          end
          if (32'(way) != cht_pkg::WAYS - 1) begin
            way <= way + 1'b1; hit_w <= hit_w + 1'b1;
          end
        end
      end
      cht_pkg::B_WRITE: if (we && wv) begin
        if (hit) begin
          mcnt[addr] <= wcnt;
        end else begin
          mkey[(cht_pkg::WAYS > 1) ? SB'({job.bucket, free_w}) : SB'(job.bucket)] <= job.key;
          mcnt[(cht_pkg::WAYS > 1) ? SB'({job.bucket, free_w}) : SB'(job.bucket)] <= wcnt;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/counting_hash_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_hash_table_top
// counting hash table of 32-bit keys with saturating counts
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; its result appears for
// one cycle with done and must be captured then. The front reduces the
// 48-bit hash product to a bucket bit-serially; the back reads and then
// checks the bucket ways from its slot memory one after another, in
// parallel with hashing of the next word through a two-entry queue.
module counting_hash_table_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  cht_pkg::in_word_t             in_word,
  output logic                          done,
  output cht_pkg::out_word_t            result,
  input  logic                          cfg_we,
  input  logic [cht_pkg::IDX_BITS-1:0]  cfg_index,
  input  logic [cht_pkg::CFG_BITS-1:0]  cfg_data
);

  logic [cht_pkg::CFG_BITS-1:0]  hash_multiplier, hash_offset;
  logic [cht_pkg::BCNT_BITS-1:0] bucket_count;
  logic q_push, q_full, q_pop, q_empty;
  cht_pkg::job_t q_in, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_multiplier <= cht_pkg::CFG_BITS'(1);
      hash_offset     <= '0;
      bucket_count    <= cht_pkg::BCNT_BITS'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        cht_pkg::REG_MULT:   hash_multiplier <= cfg_data;
        cht_pkg::REG_OFFSET: hash_offset     <= cfg_data;
        cht_pkg::REG_BCOUNT: bucket_count    <= cfg_data[cht_pkg::BCNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  cht_front u_front (
    .clk, .rst, .start, .busy, .in_word,
    .hash_multiplier, .hash_offset, .bucket_count,
    .q_full, .q_push, .q_job(q_in)
  );

  cht_queue u_queue (
    .clk, .rst, .push(q_push), .push_job(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  cht_back u_back (
    .clk, .rst, .empty(q_empty), .head(q_head), .pop(q_pop), .done, .result
  );

endmodule

FILE: rtl/cht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_checker
// port level checks of the counting hash table
// ----------------------------------------------------------------------------
module cht_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input cht_pkg::out_word_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    done && result.status |-> !result.found && result.occurrences == 16'd0)
    else $error("full result not clean");
  a_found_cnt: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.occurrences <= 16'd1)
    else $error("count without hit");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");

endmodule

bind counting_hash_table_top cht_checker u_checker (
  .clk, .rst, .start, .busy, .done, .result
);
